// ===== rtl/lbs_pkg.sv =====
`default_nettype none
package lbs_pkg;

    localparam int unsigned KindWidth  = 3;
    localparam int unsigned TimeWidth  = 32;
    localparam int unsigned CountWidth = 8;

    localparam logic [KindWidth-1:0] KIND_TICK      = 3'd0;
    localparam logic [KindWidth-1:0] KIND_FORCE_ON  = 3'd1;
    localparam logic [KindWidth-1:0] KIND_FORCE_OFF = 3'd2;
    localparam logic [KindWidth-1:0] KIND_TIMED_ON  = 3'd3;
    localparam logic [KindWidth-1:0] KIND_BLINK     = 3'd4;

    typedef enum logic [1:0] {
        MODE_STEADY = 2'd0,
        MODE_TIMED  = 2'd1,
        MODE_FLASH  = 2'd2
    } mode_t;

    typedef struct packed {
        logic [KindWidth-1:0]  kind;
        logic [TimeWidth-1:0]  duration_a;
        logic [TimeWidth-1:0]  duration_b;
        logic [CountWidth-1:0] repeats;
    } item_t;

    typedef struct packed {
        logic led_lit;
        logic active;
    } result_t;

endpackage
`default_nettype wire

// ===== rtl/lbs_in_reg.sv =====
`default_nettype none
module lbs_in_reg (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire lbs_pkg::item_t in_item,
    input  wire logic           advance,
    output logic                item_valid,
    output lbs_pkg::item_t      item
);
    import lbs_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule
`default_nettype wire

// ===== rtl/lbs_engine.sv =====
`default_nettype none
module lbs_engine (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           advance,
    input  wire lbs_pkg::item_t item,
    output lbs_pkg::result_t    result
);
    import lbs_pkg::*;

    mode_t                 mode_reg,     mode_next;
    logic                  lit_reg,      lit_next;
    logic                  led_reg,      led_next;
    logic [TimeWidth-1:0]  phase_reg,    phase_next;
    logic [TimeWidth-1:0]  on_reg,       on_next;
    logic [TimeWidth-1:0]  off_reg,      off_next;
    logic [CountWidth-1:0] cycles_reg,   cycles_next;

    logic [TimeWidth-1:0]  left;
    logic                  ran_out;
    logic [TimeWidth-1:0]  left_diff;
    logic [CountWidth-1:0] cycles_dec;

    assign left       = (mode_reg == MODE_TIMED) ? on_reg : phase_reg;
    assign ran_out    = !(item.duration_a < left);
    assign left_diff  = left - item.duration_a;
    assign cycles_dec = cycles_reg - CountWidth'(1);

    always_comb begin
        mode_next   = mode_reg;
        lit_next    = lit_reg;
        led_next    = led_reg;
        phase_next  = phase_reg;
        on_next     = on_reg;
        off_next    = off_reg;
        cycles_next = cycles_reg;
        case (item.kind)
            KIND_TICK: begin
                if (mode_reg == MODE_TIMED) begin
                    if (ran_out) begin
                        mode_next = MODE_STEADY;
                        led_next  = 1'b0;
                    end else begin
                        on_next = left_diff;
                    end
                end else if (mode_reg == MODE_FLASH) begin
                    if (!ran_out) begin
                        phase_next = left_diff;
                    end else if (lit_reg) begin
                        led_next   = 1'b0;
                        phase_next = off_reg;
                        lit_next   = 1'b0;
                    end else begin
                        cycles_next = cycles_dec;
                        if (cycles_dec == '0) begin
                            mode_next = MODE_STEADY;
                            led_next  = 1'b0;
                        end else begin
                            led_next   = 1'b1;
                            phase_next = on_reg;
                            lit_next   = 1'b1;
                        end
                    end
                end
            end
            KIND_FORCE_ON: begin
                mode_next = MODE_STEADY;
                led_next  = 1'b1;
            end
            KIND_FORCE_OFF: begin
                mode_next = MODE_STEADY;
                led_next  = 1'b0;
            end
            KIND_TIMED_ON: begin
                mode_next = MODE_TIMED;
                on_next   = item.duration_a;
                led_next  = 1'b1;
            end
            KIND_BLINK: begin
                if ((item.duration_a == '0 && item.duration_b == '0) ||
                    item.repeats == '0) begin
                    mode_next = MODE_STEADY;
                    led_next  = 1'b0;
                end else begin
                    mode_next   = MODE_FLASH;
                    on_next     = item.duration_a;
                    off_next    = item.duration_b;
                    cycles_next = item.repeats;
                    if (item.duration_a != '0) begin
                        led_next   = 1'b1;
                        lit_next   = 1'b1;
                        phase_next = item.duration_a;
                    end else begin
                        led_next   = 1'b0;
                        lit_next   = 1'b0;
                        phase_next = item.duration_b;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_STEADY;
            lit_reg    <= 1'b0;
            led_reg    <= 1'b0;
            phase_reg  <= '0;
            on_reg     <= '0;
            off_reg    <= '0;
            cycles_reg <= '0;
        end else if (advance) begin
            mode_reg   <= mode_next;
            lit_reg    <= lit_next;
            led_reg    <= led_next;
            phase_reg  <= phase_next;
            on_reg     <= on_next;
            off_reg    <= off_next;
            cycles_reg <= cycles_next;
        end
    end

    assign result.led_lit = led_next;
    assign result.active  = (mode_next != MODE_STEADY);

endmodule
`default_nettype wire

// ===== rtl/led_blink_sequencer.sv =====
`default_nettype none
// LED blink sequencer.
// Input channel s_*: one transaction per item, either a tick carrying elapsed
// milliseconds in s_duration_a, or a command (force on, force off, timed on,
// blink with on time, off time and repeat count).
// Result channel m_*: one transaction per input item, giving the LED drive
// after that item (m_led_lit, 1 lit) and whether a timed or blink sequence is
// still running (m_active).
// Path: an accepted item enters the input register; when the result register
// is empty or being taken, the item's result is loaded into the result
// register and m_valid rises.
// Throughput: one item per cycle unless the receiver stalls. The whole update
// (one 32-bit compare and subtract plus state selection) sits between the input
// and result registers. When the receiver stalls, the result register holds
// and the input register keeps one more item; s_ready drops only when both are
// full. Reset (aresetn low, synchronous) returns to manual mode with the LED off
// and all timers and counts cleared; both registers are emptied.
module led_blink_sequencer (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [lbs_pkg::KindWidth-1:0]   s_kind,
    input  wire logic [lbs_pkg::TimeWidth-1:0]   s_duration_a,
    input  wire logic [lbs_pkg::TimeWidth-1:0]   s_duration_b,
    input  wire logic [lbs_pkg::CountWidth-1:0]  s_repeats,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic                                 m_led_lit,
    output logic                                 m_active
);
    import lbs_pkg::*;

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    advance;
    result_t result;

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_reg;

    assign in_item.kind       = s_kind;
    assign in_item.duration_a = s_duration_a;
    assign in_item.duration_b = s_duration_b;
    assign in_item.repeats    = s_repeats;

    assign advance = item_valid && (!out_valid_reg || m_ready);

    lbs_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    lbs_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item),
        .result  (result)
    );

    assign out_valid_next = advance || (out_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_led_lit = out_reg.led_lit;
    assign m_active  = out_reg.active;

endmodule
`default_nettype wire
